@@ hdl/a2i_pkg.sv @@
// Package: shared types and constants of the ASCII to integer parser.
`default_nettype none
package a2i_pkg;

    localparam int A2I_MAX_LEN     = 256;
    localparam int A2I_QUEUE_DEPTH = 4;

    localparam logic [5:0] BASE_RESET = 6'd10;
    localparam logic [5:0] BASE_MAX   = 6'd36;
    localparam logic [5:0] BASE_OCT   = 6'd8;
    localparam logic [5:0] BASE_DEC   = 6'd10;
    localparam logic [5:0] BASE_HEX   = 6'd16;
    localparam logic [5:0] BASE_AUTO  = 6'd2;

    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7A;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [5:0] LETTER_OFS = 6'hA;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] parsed_value;
        logic [7:0]         stop_position;
        logic               digits_seen;
        logic               wrapped;
    } t_out_item;

    // Classified character as queued between front and back.
    typedef struct packed {
        logic [5:0] dval;
        logic       dok;
        logic       is_space;
        logic       is_minus;
        logic       is_plus;
        logic       is_zero;
        logic       is_x;
        logic       last;
    } t_cls;

    typedef enum logic [5:0] {
        PH_SKIP   = 6'b000001,
        PH_FIRST  = 6'b000010,
        PH_ZERO   = 6'b000100,
        PH_DIGITS = 6'b001000,
        PH_XSEEN  = 6'b010000,
        PH_DONE   = 6'b100000
    } t_phase;

endpackage
`default_nettype wire

@@ hdl/a2i_front.sv @@
// Front end: takes input transfers and classifies each character.
`default_nettype none
module a2i_front (
    input  wire              i_in_valid,
    input  a2i_pkg::t_in_item i_in_data,
    input  wire              i_q_full,
    output logic             o_in_stall,
    output logic             o_push,
    output a2i_pkg::t_cls    o_cls
);
    import a2i_pkg::*;

    logic [7:0] c;

    assign c          = i_in_data.char_code;
    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    always_comb begin
        o_cls          = '0;
        o_cls.is_space = (c == CH_SPACE);
        o_cls.is_minus = (c == CH_MINUS);
        o_cls.is_plus  = (c == CH_PLUS);
        o_cls.is_zero  = (c == CH_0);
        o_cls.is_x     = (c == CH_LX) || (c == CH_UX);
        o_cls.last     = i_in_data.last_char;
        if (c >= CH_0 && c <= CH_9) begin
            o_cls.dok  = 1'b1;
            o_cls.dval = 6'(c - CH_0);
        end else if (c >= CH_UA && c <= CH_UZ) begin
            o_cls.dok  = 1'b1;
            o_cls.dval = 6'(c - CH_UA) + LETTER_OFS;
        end else if (c >= CH_LA && c <= CH_LZ) begin
            o_cls.dok  = 1'b1;
            o_cls.dval = 6'(c - CH_LA) + LETTER_OFS;
        end
    end

endmodule
`default_nettype wire

@@ hdl/a2i_queue.sv @@
// Small FIFO of classified characters between front and back.
`default_nettype none
module a2i_queue #(
    parameter int DEPTH = a2i_pkg::A2I_QUEUE_DEPTH
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_push,
    input  a2i_pkg::t_cls i_data,
    input  wire           i_pop,
    output logic          o_full,
    output logic          o_valid,
    output a2i_pkg::t_cls o_data
);
    import a2i_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cls          r_mem [DEPTH];
    logic [AW-1:0] r_wp, n_wp;
    logic [AW-1:0] r_rp, n_rp;
    logic [CW-1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (i_pop) begin
            n_rp = (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule
`default_nettype wire

@@ hdl/a2i_back.sv @@
// Back end: parse state machine, multiply-add accumulator and result register.
`default_nettype none
module a2i_back #(
    parameter int MAX_LEN = a2i_pkg::A2I_MAX_LEN
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_cfg_we,
    input  wire [5:0]         i_cfg_data,
    input  wire               i_q_valid,
    input  a2i_pkg::t_cls     i_q_data,
    output logic              o_pop,
    output logic              o_out_valid,
    input  wire               i_out_stall,
    output a2i_pkg::t_out_item o_out_data
);
    import a2i_pkg::*;

    localparam int IW = (MAX_LEN > 2) ? $clog2(MAX_LEN) : 1;
    localparam int SW = IW + 1;

    logic [5:0]    r_base;
    t_phase        r_phase, n_phase;
    logic          r_neg, n_neg;
    logic [31:0]   r_acc, n_acc;
    logic [5:0]    r_ab, n_ab;
    logic [IW-1:0] r_idx, n_idx;
    logic          r_ov, n_ov;
    logic          r_any, n_any;
    logic          r_out_valid;
    t_out_item     r_out;

    logic          last, done, take, emit, autob;
    logic [5:0]    b_eff;
    logic [38:0]   prod;
    logic [SW-1:0] stop;
    logic [31:0]   mag;
    t_out_item     res;

    assign o_pop       = i_q_valid && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        b_eff   = (r_base > BASE_MAX) ? BASE_MAX : r_base;
        autob   = (b_eff < BASE_AUTO);
        last    = i_q_data.last || (r_idx == IW'(MAX_LEN - 1));
        done    = 1'b0;
        take    = 1'b0;
        emit    = 1'b0;
        stop    = '0;
        n_phase = r_phase;
        n_neg   = r_neg;
        n_acc   = r_acc;
        n_ab    = r_ab;
        n_ov    = r_ov;
        n_any   = r_any;
        prod    = '0;
        mag     = '0;
        res     = '0;
        n_idx   = r_idx;

        if (r_phase != PH_DONE) begin
            if (n_phase == PH_SKIP) begin
                if (i_q_data.is_space) begin
                    done = 1'b1;
                end else if (i_q_data.is_minus || i_q_data.is_plus) begin
                    n_neg   = i_q_data.is_minus;
                    n_phase = PH_FIRST;
                    done    = 1'b1;
                end else begin
                    n_phase = PH_FIRST;
                end
            end
            if (!done && n_phase == PH_FIRST) begin
                if (i_q_data.is_zero && (autob || b_eff == BASE_HEX)) begin
                    n_ab    = autob ? BASE_OCT : BASE_HEX;
                    n_acc   = '0;
                    n_any   = 1'b1;
                    n_phase = PH_ZERO;
                    done    = 1'b1;
                end else begin
                    n_ab    = autob ? BASE_DEC : b_eff;
                    n_phase = PH_DIGITS;
                end
            end
            if (!done && n_phase == PH_ZERO) begin
                if (i_q_data.is_x) begin
                    n_ab    = BASE_HEX;
                    n_phase = PH_XSEEN;
                    done    = 1'b1;
                end else begin
                    n_phase = PH_DIGITS;
                end
            end
            if (!done && n_phase == PH_XSEEN) begin
                if (i_q_data.dok && i_q_data.dval < BASE_HEX) begin
                    take    = 1'b1;
                    n_phase = PH_DIGITS;
                end else begin
                    emit = 1'b1;
                    stop = SW'(r_idx) - 1'b1;
                end
                done = 1'b1;
            end
            if (!done && n_phase == PH_DIGITS) begin
                if (i_q_data.dok && i_q_data.dval < n_ab) begin
                    take = 1'b1;
                end else begin
                    emit = 1'b1;
                    stop = SW'(r_idx);
                end
            end
            // single shared multiply-add for the accepted digit
            if (take) begin
                prod  = 39'(r_acc) * 39'(n_ab) + 39'(i_q_data.dval);
                n_ov  = n_ov || (prod[38:32] != '0);
                n_acc = prod[31:0];
                n_any = 1'b1;
            end
            if (last && !emit) begin
                emit = 1'b1;
                stop = (n_phase == PH_XSEEN) ? SW'(r_idx) : SW'(r_idx) + 1'b1;
            end
        end

        mag = n_neg ? (32'd0 - n_acc) : n_acc;
        if (!n_any) begin
            stop = '0;
        end
        res.parsed_value  = mag;
        res.stop_position = (stop > SW'(255)) ? 8'hFF : 8'(stop);
        res.digits_seen   = n_any;
        res.wrapped       = n_ov;

        if (last) begin
            n_phase = PH_SKIP;
            n_neg   = 1'b0;
            n_acc   = '0;
            n_ab    = '0;
            n_idx   = '0;
            n_ov    = 1'b0;
            n_any   = 1'b0;
        end else begin
            if (emit) begin
                n_phase = PH_DONE;
            end
            n_idx = r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= BASE_RESET;
            r_phase     <= PH_SKIP;
            r_neg       <= 1'b0;
            r_acc       <= '0;
            r_ab        <= '0;
            r_idx       <= '0;
            r_ov        <= 1'b0;
            r_any       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_base <= i_cfg_data;
            end
            if (o_pop) begin
                r_phase <= n_phase;
                r_neg   <= n_neg;
                r_acc   <= n_acc;
                r_ab    <= n_ab;
                r_idx   <= n_idx;
                r_ov    <= n_ov;
                r_any   <= n_any;
            end
            if (o_pop && emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && emit) begin
            r_out <= res;
        end
    end

endmodule
`default_nettype wire

@@ hdl/ascii_to_integer_parser.sv @@
// Top level: strtol-style ASCII string to 32-bit integer converter.
//
// Usage:
//  - Input channel (i_in_valid / o_in_stall / i_in_data): one character per
//    transfer, last_char set on the final character of each string.
//  - Output channel (o_out_valid / i_out_stall / o_out_data): exactly one
//    result per string: value, stop position, digits seen, wrap flag.
//  - Config: i_cfg_we writes the 6-bit radix from i_cfg_data; 0 or 1 selects
//    auto (0x -> hex, leading 0 -> octal, else decimal). Write only when idle.
//  - Throughput: one character per cycle while the output is not stalled. The
//    per-character multiply-add (32 x 6 bits) in the back end is combinational.
//  - Result path: the character that ends the number is written into the queue,
//    then taken by the back end, which writes the result into the output
//    register.
//  - Receiver stall: the result holds in the output register; the back end
//    stops, the queue fills (QUEUE_DEPTH entries) and then o_in_stall rises.
//    The front keeps taking characters while a result waits.
//  - Reset (synchronous, active low): queue emptied, parse state cleared,
//    radix returns to 10, no result pending.
`default_nettype none
module ascii_to_integer_parser #(
    parameter int MAX_LEN     = a2i_pkg::A2I_MAX_LEN,
    parameter int QUEUE_DEPTH = a2i_pkg::A2I_QUEUE_DEPTH
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_cfg_we,
    input  wire [5:0]          i_cfg_data,
    input  wire                i_in_valid,
    output logic               o_in_stall,
    input  a2i_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  wire                i_out_stall,
    output a2i_pkg::t_out_item o_out_data
);
    import a2i_pkg::*;

    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_valid;
    t_cls cls_in;
    t_cls cls_out;

    // front: classify characters and push them into the queue
    a2i_front u_front (
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .i_q_full   (q_full),
        .o_in_stall (o_in_stall),
        .o_push     (q_push),
        .o_cls      (cls_in)
    );

    // queue decouples front stall from back stall
    a2i_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (cls_in),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (cls_out)
    );

    // back: parse state, accumulation and the result register
    a2i_back #(
        .MAX_LEN (MAX_LEN)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_q_valid   (q_valid),
        .i_q_data    (cls_out),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
`default_nettype wire

@@ hdl/a2i_checker.sv @@
// Checker: port-level assertions for the parser, bound to the top level.
`default_nettype none
module a2i_checker (
    input wire                i_clk,
    input wire                i_rst_n,
    input wire                o_in_stall,
    input wire                o_out_valid,
    input wire                i_out_stall,
    input a2i_pkg::t_out_item o_out_data
);
    import a2i_pkg::*;

    // no result pending right after reset
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // queue is empty after reset, so input is never stalled then
    a_rst_in: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_stall)
        else $error("input stalled after reset");

    // a result without digits is all zero
    a_nodigit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.digits_seen) |->
        (o_out_data.parsed_value == 32'sd0 && o_out_data.stop_position == 8'd0
         && !o_out_data.wrapped))
        else $error("empty parse with nonzero fields");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed");

endmodule

bind ascii_to_integer_parser a2i_checker u_a2i_checker (.*);
`default_nettype wire
